[design/fdc_pkg.sv]
package fdc_pkg;

  localparam logic [7:0]  SyncByte1 = 8'hAA;
  localparam logic [7:0]  SyncByte2 = 8'h55;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] CrcSeed   = 16'hFFFF;

  typedef enum logic [7:0] {
    PH_SYNC1  = 8'b0000_0001,
    PH_SYNC2  = 8'b0000_0010,
    PH_LEN_LO = 8'b0000_0100,
    PH_LEN_HI = 8'b0000_1000,
    PH_TYPE   = 8'b0001_0000,
    PH_DATA   = 8'b0010_0000,
    PH_CRC_LO = 8'b0100_0000,
    PH_CRC_HI = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic        is_end;
    logic        crc_good;
    logic [15:0] frame_length;
  } res_t;

endpackage

[design/fdc_if.sv]
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [7:0]  frame_type;
  logic        is_end;
  logic        crc_good;
  logic [15:0] frame_length;

  modport source (output valid, output data_byte, output frame_type, output is_end,
                  output crc_good, output frame_length, input ready);
  modport sink   (input valid, input data_byte, input frame_type, input is_end,
                  input crc_good, input frame_length, output ready);
endinterface

[design/fdc_crc16.sv]
module fdc_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ fdc_pkg::CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

[design/fdc_parser.sv]
module fdc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  output logic              res_valid_o,
  output fdc_pkg::res_t     res_o,
  output fdc_pkg::phase_e   phase_o
);

  fdc_pkg::phase_e phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] crc_in, crc_next;

  assign crc_in = (phase_q == fdc_pkg::PH_TYPE) ? fdc_pkg::CrcSeed : crc_q;

  fdc_crc16 u_crc (
    .crc_i  (crc_in),
    .byte_i (in_byte_i),
    .crc_o  (crc_next)
  );

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    type_d      = type_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (phase_q)
        fdc_pkg::PH_SYNC1: begin
          if (in_byte_i == fdc_pkg::SyncByte1) phase_d = fdc_pkg::PH_SYNC2;
        end
        fdc_pkg::PH_SYNC2: begin
          phase_d = (in_byte_i == fdc_pkg::SyncByte2) ? fdc_pkg::PH_LEN_LO
                                                      : fdc_pkg::PH_SYNC1;
        end
        fdc_pkg::PH_LEN_LO: begin
          len_d   = {8'h00, in_byte_i};
          phase_d = fdc_pkg::PH_LEN_HI;
        end
        fdc_pkg::PH_LEN_HI: begin
          len_d   = {in_byte_i, len_q[7:0]};
          cnt_d   = '0;
          phase_d = fdc_pkg::PH_TYPE;
        end
        fdc_pkg::PH_TYPE: begin
          type_d  = in_byte_i;
          crc_d   = crc_next;
          phase_d = (len_q == 16'd0) ? fdc_pkg::PH_CRC_LO : fdc_pkg::PH_DATA;
        end
        fdc_pkg::PH_DATA: begin
          crc_d = crc_next;
          cnt_d = cnt_q + 16'd1;
          if (cnt_d >= len_q) phase_d = fdc_pkg::PH_CRC_LO;
          res_valid_o        = 1'b1;
          res_o.data_byte    = in_byte_i;
          res_o.frame_type   = type_q;
          res_o.frame_length = len_q;
        end
        fdc_pkg::PH_CRC_LO: begin
          crc_lo_d = in_byte_i;
          phase_d  = fdc_pkg::PH_CRC_HI;
        end
        fdc_pkg::PH_CRC_HI: begin
          res_valid_o        = 1'b1;
          res_o.frame_type   = type_q;
          res_o.is_end       = 1'b1;
          res_o.crc_good     = ({in_byte_i, crc_lo_q} == crc_q);
          res_o.frame_length = len_q;
          phase_d  = fdc_pkg::PH_SYNC1;
          len_d    = '0;
          cnt_d    = '0;
          type_d   = '0;
          crc_d    = fdc_pkg::CrcSeed;
          crc_lo_d = '0;
        end
        default: phase_d = fdc_pkg::PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= fdc_pkg::PH_SYNC1;
      len_q    <= '0;
      cnt_q    <= '0;
      type_q   <= '0;
      crc_q    <= fdc_pkg::CrcSeed;
      crc_lo_q <= '0;
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      type_q   <= type_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  assign phase_o = phase_q;

endmodule

[design/fdc_out_reg.sv]
module fdc_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  fdc_pkg::res_t res_i,
  output logic          ready_o,
  fdc_out_if.source     out_o
);

  logic          valid_q;
  fdc_pkg::res_t res_q;

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.data_byte    = res_q.data_byte;
  assign out_o.frame_type   = res_q.frame_type;
  assign out_o.is_end       = res_q.is_end;
  assign out_o.crc_good     = res_q.crc_good;
  assign out_o.frame_length = res_q.frame_length;

endmodule

[design/frame_deframer_crc16.sv]
// Byte-stream deframer with CRC-16/CCITT-FALSE check.
// in_i carries one received link byte per item. The block hunts for the
// sync pair 0xAA 0x55, takes a little-endian length, a type byte, the
// payload and a little-endian CRC over type and payload.
// out_o items: one per payload byte (is_end = 0), then one end item
// (is_end = 1) with type, length and crc_good after the last CRC byte.
// Header and CRC bytes give no item.
// A result appears on out_o in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_i.ready is high; the per-byte CRC
// update is a single combinational XOR network between the state registers.
// A single output register separates the sides: in_i.ready is high while
// that register is empty or being drained, so a stalled receiver stops
// input only once a result is waiting.
// Reset: the parser returns to the sync hunt, the CRC to 0xFFFF, and the
// output register empties. After every end item the parser also returns
// to the hunt, whatever the CRC result.
module frame_deframer_crc16 (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdc_in_if.sink     in_i,
  fdc_out_if.source  out_o
);

  logic            ready;
  logic            res_valid;
  fdc_pkg::res_t   res;
  logic            accept;
  fdc_pkg::phase_e phase;

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  fdc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_i.in_byte),
    .res_valid_o (res_valid),
    .res_o       (res),
    .phase_o     (phase)
  );

  fdc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (ready),
    .out_o       (out_o)
  );

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase))
    else $error("parser phase not one-hot");

  a_end_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase == fdc_pkg::PH_CRC_HI
    |=> out_o.valid && out_o.is_end && phase == fdc_pkg::PH_SYNC1)
    else $error("second CRC byte did not produce an end item");

  a_header_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (phase == fdc_pkg::PH_SYNC1 || phase == fdc_pkg::PH_SYNC2
      || phase == fdc_pkg::PH_LEN_LO || phase == fdc_pkg::PH_LEN_HI
      || phase == fdc_pkg::PH_TYPE || phase == fdc_pkg::PH_CRC_LO)
    |=> !out_o.valid)
    else $error("header or CRC byte produced an item");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.is_end ? out_o.data_byte == 8'h00 : !out_o.crc_good))
    else $error("inconsistent result item fields");

endmodule

[dv/frame_deframer_crc16_tb.sv]
module frame_deframer_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ItemTarget = 1200;
  localparam int unsigned LongLen    = 400;

  typedef struct {
    logic [7:0] value;
    bit         quiet;
  } link_byte_t;

  logic clk_i;
  logic rst_ni;

  fdc_in_if  in_if ();
  fdc_out_if out_if ();

  frame_deframer_crc16 uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  link_byte_t     link_q[$];
  fdc_pkg::res_t  exp_q[$];

  // deframer shadow state
  fdc_pkg::phase_e rx_phase;
  logic [15:0] hdr_len;
  logic [15:0] pay_count;
  logic [7:0]  hdr_type;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;

  link_byte_t  drv_item = '{value: 8'h00, quiet: 1'b0};
  bit          drv_busy = 1'b0;
  bit          drv_quiet = 1'b0;
  int unsigned drv_gap = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned rx_wait = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_results = 0;
  int unsigned n_ends = 0;
  int unsigned n_bad_ends = 0;
  int unsigned n_frames = 0;
  fdc_pkg::res_t got_res;

  function automatic logic [15:0] crc16_ccitt_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ fdc_pkg::CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic int unsigned gap_draw(bit quiet);
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic clear_deframer();
    rx_phase  = fdc_pkg::PH_SYNC1;
    hdr_len   = '0;
    pay_count = '0;
    hdr_type  = '0;
    crc_acc   = fdc_pkg::CrcSeed;
    crc_lo    = '0;
  endtask

  task automatic deframe_byte(logic [7:0] b);
    fdc_pkg::res_t r;
    case (rx_phase)
      fdc_pkg::PH_SYNC1: begin
        if (b == fdc_pkg::SyncByte1) rx_phase = fdc_pkg::PH_SYNC2;
      end
      fdc_pkg::PH_SYNC2: begin
        rx_phase = (b == fdc_pkg::SyncByte2) ? fdc_pkg::PH_LEN_LO : fdc_pkg::PH_SYNC1;
      end
      fdc_pkg::PH_LEN_LO: begin
        hdr_len  = {8'h00, b};
        rx_phase = fdc_pkg::PH_LEN_HI;
      end
      fdc_pkg::PH_LEN_HI: begin
        hdr_len[15:8] = b;
        pay_count     = '0;
        rx_phase      = fdc_pkg::PH_TYPE;
      end
      fdc_pkg::PH_TYPE: begin
        hdr_type = b;
        crc_acc  = crc16_ccitt_step(fdc_pkg::CrcSeed, b);
        rx_phase = (hdr_len == 16'd0) ? fdc_pkg::PH_CRC_LO : fdc_pkg::PH_DATA;
      end
      fdc_pkg::PH_DATA: begin
        crc_acc   = crc16_ccitt_step(crc_acc, b);
        pay_count = pay_count + 16'd1;
        if (pay_count >= hdr_len) rx_phase = fdc_pkg::PH_CRC_LO;
        r.data_byte    = b;
        r.frame_type   = hdr_type;
        r.is_end       = 1'b0;
        r.crc_good     = 1'b0;
        r.frame_length = hdr_len;
        exp_q = {exp_q, r};
      end
      fdc_pkg::PH_CRC_LO: begin
        crc_lo   = b;
        rx_phase = fdc_pkg::PH_CRC_HI;
      end
      default: begin
        r.data_byte    = 8'h00;
        r.frame_type   = hdr_type;
        r.is_end       = 1'b1;
        r.crc_good     = ({b, crc_lo} == crc_acc);
        r.frame_length = hdr_len;
        exp_q = {exp_q, r};
        clear_deframer();
      end
    endcase
  endtask

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_result(fdc_pkg::res_t got);
    fdc_pkg::res_t want;
    n_results++;
    if (got.is_end) n_ends++;
    if (got.is_end && !got.crc_good) n_bad_ends++;
    if (exp_q.size() == 0) begin
      report_mismatch($sformatf("item with none expected: data %h type %h end %b",
                                got.data_byte, got.frame_type, got.is_end));
      return;
    end
    want = exp_q.pop_front();
    if (got.data_byte !== want.data_byte)
      report_mismatch($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
    if (got.frame_type !== want.frame_type)
      report_mismatch($sformatf("frame_type %h, expected %h", got.frame_type, want.frame_type));
    if (got.is_end !== want.is_end)
      report_mismatch($sformatf("is_end %b, expected %b", got.is_end, want.is_end));
    if (got.crc_good !== want.crc_good)
      report_mismatch($sformatf("crc_good %b, expected %b", got.crc_good, want.crc_good));
    if (got.frame_length !== want.frame_length)
      report_mismatch($sformatf("frame_length %h, expected %h",
                                got.frame_length, want.frame_length));
  endtask

  task automatic push_byte(logic [7:0] b, bit quiet);
    link_byte_t it;
    it.value = b;
    it.quiet = quiet;
    link_q = {link_q, it};
  endtask

  task automatic push_frame(logic [7:0] payload[$], logic [7:0] ftype, bit bad_crc, bit quiet);
    logic [15:0] len;
    logic [15:0] crc;
    len = 16'(payload.size());
    crc = crc16_ccitt_step(fdc_pkg::CrcSeed, ftype);
    push_byte(fdc_pkg::SyncByte1, quiet);
    push_byte(fdc_pkg::SyncByte2, quiet);
    push_byte(len[7:0], quiet);
    push_byte(len[15:8], quiet);
    push_byte(ftype, quiet);
    foreach (payload[i]) begin
      crc = crc16_ccitt_step(crc, payload[i]);
      push_byte(payload[i], quiet);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    push_byte(crc[7:0], quiet);
    push_byte(crc[15:8], quiet);
    n_frames++;
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        drv_busy = 1'b0;
        drv_gap  = gap_draw(drv_quiet);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (link_q.size() != 0) begin
          drv_item  = link_q.pop_front();
          drv_quiet = drv_item.quiet;
          drv_busy  = 1'b1;
        end
      end
      in_if.valid   <= drv_busy;
      in_if.in_byte <= drv_item.value;
    end
  end

  // receiver, with one long hold-off to back up the input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        rx_wait   = gap_draw(drv_quiet);
        if (!hold_done && n_results >= 40 && !drv_quiet) begin
          hold_done = 1'b1;
          rx_wait   = HoldCycles;
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cycles++;
      if (out_if.valid && out_if.ready) begin
        got_res.data_byte    = out_if.data_byte;
        got_res.frame_type   = out_if.frame_type;
        got_res.is_end       = out_if.is_end;
        got_res.crc_good     = out_if.crc_good;
        got_res.frame_length = out_if.frame_length;
        check_result(got_res);
        out_taken    = 1'b1;
        stall_cycles = 0;
      end
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.in_byte);
        n_bytes++;
        in_taken     = 1'b1;
        stall_cycles = 0;
      end
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no item moved for %0d cycles", StallLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  pl[$];
    logic [7:0]  b;
    int unsigned rnd_bytes;
    int unsigned len;
    int unsigned sel;
    bit          big_done;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    out_if.ready  = 1'b0;
    clear_deframer();
    rnd_bytes = 0;
    big_done  = 1'b0;

    // broken sync: the byte after 0xAA is not a new sync start
    push_byte(fdc_pkg::SyncByte1, 1'b0);
    push_byte(fdc_pkg::SyncByte1, 1'b0);
    push_byte(fdc_pkg::SyncByte2, 1'b0);
    pl = {};
    push_frame(pl, 8'hFF, 1'b0, 1'b0);
    pl = {8'h00, 8'hFF};
    push_frame(pl, 8'h00, 1'b0, 1'b0);
    pl = {8'h55};
    push_frame(pl, 8'hA5, 1'b1, 1'b0);

    while (rnd_bytes < ItemTarget) begin
      sel = $urandom_range(0, 9);
      if (!big_done && rnd_bytes >= ItemTarget / 2) begin
        // long frame, sent back to back
        pl = {};
        for (int i = 0; i < LongLen; i++) pl = {pl, 8'($urandom)};
        push_frame(pl, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        big_done = 1'b1;
        rnd_bytes += LongLen + 7;
      end else if (sel == 0) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          do b = 8'($urandom); while (b == fdc_pkg::SyncByte1);
          push_byte(b, 1'b0);
        end
      end else if (sel == 1) begin
        push_byte(fdc_pkg::SyncByte1, 1'b0);
        do b = 8'($urandom); while (b == fdc_pkg::SyncByte2);
        push_byte(b, 1'b0);
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        pl = {};
        for (int i = 0; i < len; i++) pl = {pl, 8'($urandom)};
        push_frame(pl, 8'($urandom), ($urandom_range(0, 5) == 0),
                   ($urandom_range(0, 7) == 0));
        rnd_bytes += len + 7;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (link_q.size() != 0 || drv_busy) @(posedge clk_i);
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (exp_q.size() != 0)
      report_mismatch($sformatf("%0d expected items never came", exp_q.size()));

    $display("sent %0d link bytes in %0d frames plus noise and broken sync pairs",
             n_bytes, n_frames);
    $display("checked %0d output items: %0d frame ends, %0d with a CRC error",
             n_results, n_ends, n_bad_ends);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
